### rtl/rcrt_pkg.sv
// Shared types, constants and CRC-32 helpers for the continuous repeat test.
// Depends on nothing; every other file imports it.
package rcrt_pkg;

   localparam int WORD_W      = 32;
   localparam int TRIES_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [WORD_W-1:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [WORD_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] CRC_XOROUT = 32'hFFFF_FFFF;

   localparam logic [TRIES_W-1:0] MAX_TRIES_RESET = 8'd16;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TRIES = 2'd1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_READY = 2'd1,
      ST_DISCARDED = 2'd2,
      ST_DISABLED  = 2'd3
   } status_type;

   // One attempt as held in the input register, with its CRC
   typedef struct packed {
      logic              start_request;
      logic              sample_ready;
      logic [WORD_W-1:0] sample_word;
      logic [WORD_W-1:0] word_crc;
   } attempt_type;

   // Configuration write bundle
   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // Bit-serial reflected CRC-32; evaluated on constants at elaboration only
   function automatic logic [WORD_W-1:0] crc_serial(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] c;
      logic              b;
      c = CRC_INIT;
      for (int i = 0; i < WORD_W; i++) begin
         b = c[0] ^ w[i];
         c = (c >> 1) ^ (b ? CRC_POLY : '0);
      end
      return c ^ CRC_XOROUT;
   endfunction

   // Row j holds the input bits that feed CRC bit j (the CRC is affine in w)
   function automatic logic [WORD_W-1:0][WORD_W-1:0] crc_rows();
      logic [WORD_W-1:0][WORD_W-1:0] rows;
      logic [WORD_W-1:0]             col;
      logic [WORD_W-1:0]             unit;
      rows = '0;
      for (int i = 0; i < WORD_W; i++) begin
         unit = '0;
         unit[i] = 1'b1;
         col = crc_serial(unit) ^ crc_serial('0);
         for (int j = 0; j < WORD_W; j++) begin
            rows[j][i] = col[j];
         end
      end
      return rows;
   endfunction

   localparam logic [WORD_W-1:0]             CRC_ZERO = crc_serial('0);
   localparam logic [WORD_W-1:0][WORD_W-1:0] CRC_ROWS = crc_rows();

   // Parallel CRC-32 of one word: one parity tree per output bit
   function automatic logic [WORD_W-1:0] word_crc(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] c;
      for (int j = 0; j < WORD_W; j++) begin
         c[j] = CRC_ZERO[j] ^ (^(w & CRC_ROWS[j]));
      end
      return c;
   endfunction

endpackage

### rtl/rcrt_if.sv
// Valid/ready channel interfaces for attempts in and results out.
// Depends on rcrt_pkg for the word width.
interface rcrt_req_if;
   import rcrt_pkg::*;
   logic              valid;
   logic              ready;
   logic              start_request;
   logic              sample_ready;
   logic [WORD_W-1:0] sample_word;

   modport source (output valid, start_request, sample_ready, sample_word, input ready);
   modport sink   (input valid, start_request, sample_ready, sample_word, output ready);
endinterface

interface rcrt_rsp_if;
   import rcrt_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [WORD_W-1:0] random_word;
   logic              request_done;

   modport source (output valid, status, random_word, request_done, input ready);
   modport sink   (input valid, status, random_word, request_done, output ready);
endinterface

### rtl/rcrt_crc_stage.sv
// Input register for attempts and the parallel CRC-32 of the held word.
// Depends on rcrt_pkg and rcrt_req_if.
module rcrt_crc_stage
   import rcrt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   rcrt_req_if.sink          req_chan,
   output logic              att_valid,
   input  logic              att_ready,
   output attempt_type       att
);

   logic              valid_ff, valid_in;
   logic              start_ff, start_in;
   logic              rdy_ff, rdy_in;
   logic [WORD_W-1:0] word_ff, word_in;

   // Take a new transfer whenever the held one leaves or none is held
   assign req_chan.ready = !valid_ff || att_ready;

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      rdy_in   = rdy_ff;
      word_in  = word_ff;
      if (req_chan.ready) begin
         valid_in = req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         start_in = req_chan.start_request;
         rdy_in   = req_chan.sample_ready;
         word_in  = req_chan.sample_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      rdy_ff   <= rdy_in;
      word_ff  <= word_in;
   end

   // Present the held attempt with its CRC
   assign att_valid = valid_ff;
   assign att = '{
      start_request: start_ff,
      sample_ready:  rdy_ff,
      sample_word:   word_ff,
      word_crc:      word_crc(word_ff)
   };

endmodule

### rtl/rcrt_check.sv
// Repeat check, attempt counting, configuration registers and result register.
// Depends on rcrt_pkg and rcrt_rsp_if.
module rcrt_check
   import rcrt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  csr_write_type     csr,
   input  logic              att_valid,
   output logic              att_ready,
   input  attempt_type       att,
   rcrt_rsp_if.source        rsp_chan
);

   logic                 enable_ff, enable_in;
   logic [TRIES_W-1:0]   max_tries_ff, max_tries_in;
   logic                 seen_ff, seen_in;
   logic [WORD_W-1:0]    last_crc_ff, last_crc_in;
   logic [TRIES_W-1:0]   count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic                 done_ff, done_in;

   logic                 take;
   logic [TRIES_W-1:0]   count_base;
   logic [TRIES_W:0]     count_inc;

   // Advance when the result register is free or being emptied
   assign att_ready = !rsp_valid_ff || rsp_chan.ready;
   assign take      = att_valid && att_ready;

   assign count_base = att.start_request ? '0 : count_ff;
   assign count_inc  = {1'b0, count_base} + {{TRIES_W{1'b0}}, 1'b1};

   always_comb begin
      enable_in    = enable_ff;
      max_tries_in = max_tries_ff;
      seen_in      = seen_ff;
      last_crc_in  = last_crc_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      word_in      = word_ff;
      done_in      = done_ff;

      if (att_ready) begin
         rsp_valid_in = att_valid;
      end

      // Evaluate the attempt and update the test state on a transfer
      if (take) begin
         if (!enable_ff) begin
            status_in = ST_DISABLED;
            word_in   = '0;
            done_in   = 1'b1;
            count_in  = '0;
         end else begin
            if (!att.sample_ready) begin
               status_in = ST_NOT_READY;
               word_in   = '0;
            end else begin
               word_in     = att.sample_word;
               seen_in     = 1'b1;
               last_crc_in = att.word_crc;
               if (!seen_ff || (att.word_crc == last_crc_ff)) begin
                  status_in = ST_DISCARDED;
               end else begin
                  status_in = ST_OK;
               end
            end
            done_in  = (status_in == ST_OK) || (count_inc > {1'b0, max_tries_ff});
            count_in = done_in ? '0 : count_inc[TRIES_W-1:0];
         end
      end

      // Register writes; re-arm the test when enable goes from 0 to 1
      if (csr.we) begin
         priority if (csr.index == CSR_ENABLE) begin
            enable_in = csr.data[0];
            if (csr.data[0] && !enable_ff) begin
               seen_in     = 1'b0;
               last_crc_in = '0;
            end
         end else if (csr.index == CSR_MAX_TRIES) begin
            max_tries_in = csr.data[TRIES_W-1:0];
         end else begin
            max_tries_in = max_tries_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         max_tries_ff <= MAX_TRIES_RESET;
         seen_ff      <= 1'b0;
         last_crc_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         max_tries_ff <= max_tries_in;
         seen_ff      <= seen_in;
         last_crc_ff  <= last_crc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      word_ff   <= word_in;
      done_ff   <= done_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.random_word  = word_ff;
   assign rsp_chan.request_done = done_ff;

endmodule

### rtl/rng_continuous_repeat_test.sv
// Continuous repeat test on a random generator's words, CRC-32 based.
// Pipeline: an attempt passes the input register with CRC, then the check
// and result register, before its result is valid.
// Throughput: one attempt per cycle while the result channel is not stalled; the CRC-to-stored-CRC compare sets it.
// Reset: channels empty, enable 0, max_tries 16, test state and count cleared.
module rng_continuous_repeat_test
   import rcrt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   rcrt_req_if.sink               req_chan,
   rcrt_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic          att_valid;
   logic          att_ready;
   attempt_type   att;
   csr_write_type csr;

   // Bundle the configuration write
   assign csr = '{we: csr_we, index: csr_index, data: csr_wdata};

   rcrt_crc_stage u_crc_stage (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .att_valid (att_valid),
      .att_ready (att_ready),
      .att       (att)
   );

   rcrt_check u_check (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .att_valid (att_valid),
      .att_ready (att_ready),
      .att       (att),
      .rsp_chan  (rsp_chan)
   );

endmodule
